// ===== rtl/core/tlb_page_table_translator_unit_macros.svh =====
// Assertion macros used by the translator datapath.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TLBPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TLBPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tlbpt_pkg.sv =====
// Shared constants and types for the address translator.
package tlbpt_pkg;

  localparam int ADDR_W   = 16;
  localparam int PAGE_W   = 8;
  localparam int OFFSET_W = 8;
  localparam int FRAME_W  = 8;
  localparam int CNT_W    = 32;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 256;
  localparam int FRAME_BYTES_DEF = 256;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_MISS = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic finish_hit;
    logic finish_miss;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/tlbpt_datapath.sv =====
// Datapath: TLB, page table, frame allocator, counters and result register.
`include "tlb_page_table_translator_unit_macros.svh"

module tlbpt_datapath #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
  parameter int FRAME_BYTES = tlbpt_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tlbpt_pkg::cmd_t                cmd,
  output tlbpt_pkg::status_t             status,
  input  logic [tlbpt_pkg::ADDR_W-1:0]   logical_address,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [tlbpt_pkg::ADDR_W-1:0]   physical_address,
  output logic                           tlb_hit,
  output logic                           page_fault,
  output logic [tlbpt_pkg::CNT_W-1:0]    hit_total,
  output logic [tlbpt_pkg::CNT_W-1:0]    fault_total
);
  import tlbpt_pkg::*;

  localparam int TI_W     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  // Page numbers are eight bits wide, so no more than 256 table rows are reachable.
  localparam int PT_DEPTH = (PAGE_COUNT < (1 << PAGE_W)) ? PAGE_COUNT : (1 << PAGE_W);
  localparam int PT_W     = $clog2(PT_DEPTH);
  localparam int PROD_RAW = FRAME_W + $clog2(FRAME_BYTES + 1);
  localparam int PROD_W   = (PROD_RAW > ADDR_W) ? PROD_RAW : ADDR_W;
  localparam int REM_W    = 13;

  logic [ADDR_W-1:0]   addr_q;
  logic [PAGE_W-1:0]   page;
  logic [OFFSET_W-1:0] offset;

  logic [PAGE_W-1:0]      tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [TI_W-1:0]        tlb_next;

  logic [FRAME_W-1:0]  page_frame [PT_DEPTH];
  logic [PT_DEPTH-1:0] pt_valid;
  logic [FRAME_W-1:0]  pt_rdata;
  logic [PT_W-1:0]     pidx;
  logic                pt_present;

  logic [FRAME_W-1:0] next_frame;
  logic [CNT_W-1:0]   hit_counter;
  logic [CNT_W-1:0]   fault_counter;
  logic [CNT_W-1:0]   hit_counter_next;
  logic [CNT_W-1:0]   fault_counter_next;

  logic               hit;
  logic [FRAME_W-1:0] match_frame;
  logic [FRAME_W-1:0] res_frame;
  logic [PROD_W-1:0]  product;
  logic               finish;
  logic               out_full;

  // Page number modulo the table depth by restoring subtraction; the quotient is at most 15.
  function automatic logic [PT_W-1:0] page_index(input logic [PAGE_W-1:0] pg);
    logic [REM_W-1:0] rem;
    rem = REM_W'(pg);
    for (int k = 3; k >= 0; k--) begin
      if (rem >= REM_W'(PT_DEPTH << k)) begin
        rem = rem - REM_W'(PT_DEPTH << k);
      end
    end
    return rem[PT_W-1:0];
  endfunction

  assign page   = addr_q[ADDR_W-1:OFFSET_W];
  assign offset = addr_q[OFFSET_W-1:0];
  assign pidx   = page_index(page);
  assign finish = cmd.finish_hit | cmd.finish_miss;

  // Fully associative search; the lowest matching entry wins.
  always_comb begin
    hit         = 1'b0;
    match_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (tlb_page[i] == page)) begin
        hit         = 1'b1;
        match_frame = tlb_frame[i];
      end
    end
  end

  assign pt_present = pt_valid[pidx];

  always_comb begin
    if (cmd.finish_hit) begin
      res_frame = match_frame;
    end else if (pt_present) begin
      res_frame = pt_rdata;
    end else begin
      res_frame = next_frame;
    end
  end

  assign product            = PROD_W'(res_frame) * PROD_W'(FRAME_BYTES) + PROD_W'(offset);
  assign hit_counter_next   = hit_counter + CNT_W'(1);
  assign fault_counter_next = fault_counter + CNT_W'(1);

  assign status.hit      = hit;
  assign status.out_free = !out_full || !result_stall;
  assign result_valid    = out_full;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= logical_address;
    end
  end

  // Page table memory: one write port, registered read at the current page index.
  always_ff @(posedge clk) begin
    if (cmd.finish_miss && !pt_present) begin
      page_frame[pidx] <= next_frame;
    end
    pt_rdata <= page_frame[pidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_miss) begin
      tlb_page[tlb_next]  <= page;
      tlb_frame[tlb_next] <= res_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid     <= '0;
      tlb_next      <= '0;
      pt_valid      <= '0;
      next_frame    <= '0;
      hit_counter   <= '0;
      fault_counter <= '0;
    end else begin
      if (cmd.finish_hit) begin
        hit_counter <= hit_counter_next;
      end
      if (cmd.finish_miss) begin
        tlb_valid[tlb_next] <= 1'b1;
        if (tlb_next == TI_W'(TLB_ENTRIES - 1)) begin
          tlb_next <= '0;
        end else begin
          tlb_next <= tlb_next + TI_W'(1);
        end
        if (!pt_present) begin
          pt_valid[pidx] <= 1'b1;
          next_frame     <= next_frame + FRAME_W'(1);
          fault_counter  <= fault_counter_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (finish) begin
      out_full <= 1'b1;
    end else if (!result_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      physical_address <= product[ADDR_W-1:0];
      tlb_hit          <= cmd.finish_hit;
      page_fault       <= cmd.finish_miss && !pt_present;
      hit_total        <= cmd.finish_hit ? hit_counter_next : hit_counter;
      fault_total      <= (cmd.finish_miss && !pt_present) ? fault_counter_next
                                                           : fault_counter;
    end
  end

  `TLBPT_ASSERT_NOW(a_flags_exclusive, result_valid, !(tlb_hit && page_fault), "hit and fault both set")
  `TLBPT_ASSERT_NOW(a_no_overwrite, finish, !out_full || !result_stall, "result word overwritten")
  `TLBPT_ASSERT_NEXT(a_fault_count, cmd.finish_miss && !pt_present, fault_counter == $past(fault_counter) + CNT_W'(1), "fault count not advanced")
  `TLBPT_ASSERT_NEXT(a_hit_total, cmd.finish_hit, hit_total == hit_counter, "hit total disagrees with counter")
  `TLBPT_ASSERT_NEXT(a_miss_fills_tlb, cmd.finish_miss, tlb_valid[$past(tlb_next)], "miss left TLB slot empty")

endmodule

// ===== rtl/core/tlbpt_ctrl.sv =====
// Controller: sequences accept, TLB search, page table access and result hand-off.
module tlbpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               addr_valid,
  output logic               addr_stall,
  input  tlbpt_pkg::status_t status,
  output tlbpt_pkg::cmd_t    cmd
);
  import tlbpt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    addr_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (addr_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        // A hit completes here if out_free; a miss goes on to the page table read.
        if (status.hit) begin
          if (status.out_free) begin
            cmd.finish_hit = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        if (status.out_free) begin
          cmd.finish_miss = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/tlb_page_table_translator_unit.sv =====
// Top level of the TLB and demand paging address translator.
//
//   Channel  Handshake                    Word
//   addr     addr_valid / addr_stall      logical_address
//   result   result_valid / result_stall  physical_address, tlb_hit, page_fault,
//                                         hit_total, fault_total
//
// A TLB hit is loaded into the output register from S_LOOK and a miss from S_MISS;
// the extra state on a miss covers the registered read of the page table.
// One word is in translation at a time; the next is accepted in the cycle after
// the result is loaded into the output register, even while that result waits.
// Reset empties the TLB and the page table valid bits at once; no clearing pass.
// While result_stall holds a full output register, a finished translation waits.
module tlb_page_table_translator_unit #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
  parameter int FRAME_BYTES = tlbpt_pkg::FRAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         addr_valid,
  output logic                         addr_stall,
  input  logic [tlbpt_pkg::ADDR_W-1:0] logical_address,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [tlbpt_pkg::ADDR_W-1:0] physical_address,
  output logic                         tlb_hit,
  output logic                         page_fault,
  output logic [tlbpt_pkg::CNT_W-1:0]  hit_total,
  output logic [tlbpt_pkg::CNT_W-1:0]  fault_total
);
  import tlbpt_pkg::*;

  cmd_t    cmd;
  status_t status;

  tlbpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .addr_valid (addr_valid),
    .addr_stall (addr_stall),
    .status     (status),
    .cmd        (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .logical_address  (logical_address),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hit_total        (hit_total),
    .fault_total      (fault_total)
  );

endmodule

// ===== dv/tb_tlb_page_table_translator_unit.sv =====
// Self-checking testbench for the TLB and demand paging address translator.
`timescale 1ns / 100ps

module tb_tlb_page_table_translator_unit;
  import tlbpt_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] phys;
    logic              hit;
    logic              fault;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  faults;
  } xlat_t;

  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              addr_valid = 1'b0;
  logic              addr_stall;
  logic [ADDR_W-1:0] logical_address = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [ADDR_W-1:0] physical_address;
  logic              tlb_hit;
  logic              page_fault;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  fault_total;

  // Shadow copy of the translator state.
  logic [PAGE_W-1:0]  tlb_pg [TLB_ENTRIES_DEF];
  logic [FRAME_W-1:0] tlb_fr [TLB_ENTRIES_DEF];
  bit                 tlb_vld [TLB_ENTRIES_DEF] = '{default: 1'b0};
  int                 fifo_ptr = 0;
  logic [FRAME_W-1:0] pt_frame [PAGE_COUNT_DEF];
  bit                 pt_vld [PAGE_COUNT_DEF] = '{default: 1'b0};
  logic [FRAME_W-1:0] free_frame = '0;
  logic [CNT_W-1:0]   hit_count = '0;
  logic [CNT_W-1:0]   fault_count = '0;

  xlat_t pending_xlat [$];
  xlat_t want;
  int    err_count = 0;
  int    words_sent = 0;
  int    words_checked = 0;
  int    hits_seen = 0;
  int    faults_seen = 0;
  int    burst_left = 0;
  int    stall_mode = STALL_NONE;
  int    stall_cnt = 0;

  tlb_page_table_translator_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .addr_valid       (addr_valid),
    .addr_stall       (addr_stall),
    .logical_address  (logical_address),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hit_total        (hit_total),
    .fault_total      (fault_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic xlat_t translate(input logic [ADDR_W-1:0] addr);
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic [FRAME_W-1:0]  frame;
    int                  pidx;
    bit                  found;
    xlat_t               r;
    page   = addr[ADDR_W-1 -: PAGE_W];
    offset = addr[OFFSET_W-1:0];
    frame  = '0;
    found  = 1'b0;
    r      = '0;
    for (int i = 0; i < TLB_ENTRIES_DEF; i++) begin
      if (!found && tlb_vld[i] && tlb_pg[i] == page) begin
        frame = tlb_fr[i];
        found = 1'b1;
      end
    end
    if (found) begin
      hit_count++;
    end else begin
      pidx = page % PAGE_COUNT_DEF;
      if (!pt_vld[pidx]) begin
        pt_frame[pidx] = free_frame;
        pt_vld[pidx]   = 1'b1;
        free_frame++;
        fault_count++;
        r.fault = 1'b1;
      end
      frame = pt_frame[pidx];
      tlb_pg[fifo_ptr]  = page;
      tlb_fr[fifo_ptr]  = frame;
      tlb_vld[fifo_ptr] = 1'b1;
      fifo_ptr = (fifo_ptr + 1) % TLB_ENTRIES_DEF;
    end
    r.phys   = ADDR_W'(32'(frame) * FRAME_BYTES_DEF + 32'(offset));
    r.hit    = found;
    r.hits   = hit_count;
    r.faults = fault_count;
    return r;
  endfunction

  // Presents one address word, waits for it to be taken, then may idle between bursts.
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    bit taken;
    int gap;
    addr_valid      <= 1'b1;
    logical_address <= addr;
    do begin
      @(negedge clk);
      taken = !addr_stall;
      @(posedge clk);
    end while (!taken);
    pending_xlat.push_back(translate(addr));
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        addr_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                             input logic [CNT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      err_count++;
    end
  endtask

  // Outputs settle well before the falling edge, so the result word is judged there.
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_xlat.size() == 0) begin
        $error("result word arrived with nothing outstanding");
        err_count++;
      end else begin
        want = pending_xlat.pop_front();
        check_field("physical_address", CNT_W'(want.phys), CNT_W'(physical_address));
        check_field("tlb_hit", CNT_W'(want.hit), CNT_W'(tlb_hit));
        check_field("page_fault", CNT_W'(want.fault), CNT_W'(page_fault));
        check_field("hit_total", want.hits, hit_total);
        check_field("fault_total", want.faults, fault_total);
        words_checked++;
        if (want.hit) hits_seen++;
        if (want.fault) faults_seen++;
      end
    end
  end

  // The receiver switches at random among its stall modes, counted off by stall_cnt.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(STALL_NONE, STALL_PERIODIC);
      case (stall_mode)
        STALL_NONE:     result_stall <= 1'b0;
        STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
        default:        result_stall <= (stall_cnt % 16 >= 8);
      endcase
    end
  end

  task automatic test_directed();
    send_address(16'h0000);
    send_address(16'h00FF);
    send_address(16'hFFFF);
    send_address(16'hFF00);
    // Fourteen more pages fill the TLB; page 15 then evicts the oldest entry.
    for (int p = 1; p <= 15; p++) send_address({8'(p), 8'(p * 17)});
    // Page 0 now misses in the TLB but is already in the page table.
    send_address(16'h0012);
    send_address(16'hAA55);
    send_address(16'h55AA);
  endtask

  task automatic test_working_set();
    logic [PAGE_W-1:0] pages [16];
    int                set_size;
    int                target;
    target = words_sent + 700;
    while (words_sent < target) begin
      set_size = $urandom_range(1, 16);
      for (int i = 0; i < set_size; i++) pages[i] = PAGE_W'($urandom_range(0, 255));
      repeat (set_size * $urandom_range(2, 6))
        send_address({pages[$urandom_range(0, set_size - 1)], 8'($urandom_range(0, 255))});
    end
  endtask

  task automatic test_fifo_thrash();
    logic [PAGE_W-1:0] pages [24];
    int                set_size;
    int                target;
    target = words_sent + 400;
    while (words_sent < target) begin
      set_size = $urandom_range(17, 24);
      for (int i = 0; i < set_size; i++) pages[i] = PAGE_W'($urandom_range(0, 255));
      repeat ($urandom_range(2, 3))
        for (int i = 0; i < set_size; i++)
          send_address({pages[i], 8'($urandom_range(0, 255))});
    end
  endtask

  // Touching every page drives the free frame pointer through 255 and back to 0.
  task automatic test_page_sweep();
    logic [PAGE_W-1:0] order [PAGE_COUNT_DEF];
    logic [PAGE_W-1:0] tmp;
    int                j;
    for (int i = 0; i < PAGE_COUNT_DEF; i++) order[i] = PAGE_W'(i);
    for (int i = PAGE_COUNT_DEF - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < PAGE_COUNT_DEF; i++)
      send_address({order[i], 8'($urandom_range(0, 255))});
  endtask

  task automatic test_random_noise();
    repeat (600) send_address(ADDR_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_working_set();
    test_fifo_thrash();
    test_random_noise();
    test_page_sweep();
    addr_valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d translations from %0d addresses sent.", words_checked, words_sent);
    $display("TLB hits %0d, page faults %0d, next free frame %0d.",
             hits_seen, faults_seen, free_frame);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== tlb_page_table_translator_unit.f =====
+incdir+rtl/core
rtl/core/tlbpt_pkg.sv
rtl/core/tlbpt_datapath.sv
rtl/core/tlbpt_ctrl.sv
rtl/core/tlb_page_table_translator_unit.sv
dv/tb_tlb_page_table_translator_unit.sv
